[rtl/core/rrd_pkg.sv]
// Package for the receive ring deframer: record phase and result kind codes,
// framing constants and the register reset value. No dependencies.
package rrd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned KindW   = 3;

  localparam logic [LenW-1:0] HeaderBytes     = 16'd4;
  localparam logic [LenW-1:0] CrcBytes        = 16'd4;
  localparam logic [LenW-1:0] ReadPtrBias     = 16'd16;
  localparam logic [LenW-1:0] MaxLenResetVal  = 16'd2048;

  typedef enum logic [2:0] {
    PH_H0      = 3'd0,
    PH_H1      = 3'd1,
    PH_H2      = 3'd2,
    PH_H3      = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TAIL    = 3'd5
  } phase_e;

  typedef enum logic [KindW-1:0] {
    KIND_SKIP    = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_LAST    = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  payload_byte;
    logic [LenW-1:0]   read_pointer;
  } result_t;

endpackage

[rtl/core/receive_ring_deframer.sv]
// Receive ring deframer: parses ring bytes into records, one result per byte.
// Depends on rrd_pkg.
//
// Latency: each result is registered, in the result register or the skid.
// Throughput: one byte per cycle while the skid is empty; the header/payload/tail
// counters and the length compare are combinational between input and result register.
// A two-deep output stage (result register plus skid) keeps input flowing
// while one result waits. Reset clears phase, counters, offset and the
// maximum length register (to 2048); no clearing pass.
module receive_ring_deframer
  import rrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,      // max_record_length
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ring_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [7:0] payload_byte, [23:8] read_pointer
  output logic [2:0]  m_axis_tuser_o    // [2:0] kind
);

  logic [LenW-1:0]   max_len_q;
  phase_e            phase_q, phase_d;
  logic [LenW-1:0]   rec_len_q, rec_len_d;
  logic [CountW-1:0] done_q, done_d;
  logic [LenW-1:0]   offset_q, offset_d;

  result_t           res_d, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              accept;

  logic [ByteW-1:0]  in_byte;
  logic [LenW-1:0]   len_full;
  logic [CountW-1:0] done_inc;
  logic [CountW-1:0] padded;
  logic [LenW-1:0]   offset_sum;
  logic              len_bad;

  assign in_byte    = s_axis_tdata_i;
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign len_full   = {in_byte, rec_len_q[ByteW-1:0]};
  assign len_bad    = (len_full < CrcBytes) || (len_full > max_len_q);
  assign done_inc   = done_q + CountW'(1);
  assign padded     = ({1'b0, rec_len_q} + CountW'(HeaderBytes) + CountW'(3))
                      & ~CountW'(3);
  assign offset_sum = (offset_q + rec_len_q + HeaderBytes + LenW'(3)) & ~LenW'(3);

  // next state
  always_comb begin
    phase_d   = phase_q;
    rec_len_d = rec_len_q;
    done_d    = done_q;
    offset_d  = offset_q;
    case (phase_q)
      PH_H1: begin
        phase_d = PH_H2;
        done_d  = CountW'(2);
      end
      PH_H2: begin
        rec_len_d = LenW'(in_byte);
        phase_d   = PH_H3;
        done_d    = CountW'(3);
      end
      PH_H3: begin
        if (len_bad) begin
          offset_d  = '0;
          phase_d   = PH_H0;
          done_d    = '0;
          rec_len_d = '0;
        end else begin
          rec_len_d = len_full;
          done_d    = CountW'(HeaderBytes);
          phase_d   = (len_full > CrcBytes) ? PH_PAYLOAD : PH_TAIL;
        end
      end
      PH_PAYLOAD: begin
        done_d = done_inc;
        if (done_inc >= {1'b0, rec_len_q}) begin
          phase_d = PH_TAIL;
        end
      end
      PH_TAIL: begin
        done_d = done_inc;
        if (done_inc >= padded) begin
          offset_d = offset_sum;
          phase_d  = PH_H0;
          done_d   = '0;
        end
      end
      default: begin
        phase_d = PH_H1;
        done_d  = CountW'(1);
      end
    endcase
  end

  // result
  always_comb begin
    res_d.kind         = KIND_SKIP;
    res_d.payload_byte = '0;
    case (phase_q)
      PH_H3: begin
        if (len_bad) begin
          res_d.kind = KIND_ERROR;
        end
      end
      PH_PAYLOAD: begin
        res_d.payload_byte = in_byte;
        res_d.kind = (done_inc >= {1'b0, rec_len_q}) ? KIND_LAST : KIND_PAYLOAD;
      end
      PH_TAIL: begin
        if (done_inc >= padded) begin
          res_d.kind = KIND_DONE;
        end
      end
      default: begin
        res_d.kind = KIND_SKIP;
      end
    endcase
    res_d.read_pointer = offset_d - ReadPtrBias;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenResetVal;
      phase_q   <= PH_H0;
      rec_len_q <= '0;
      done_q    <= '0;
      offset_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_len_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q   <= phase_d;
        rec_len_q <= rec_len_d;
        done_q    <= done_d;
        offset_q  <= offset_d;
      end
    end
  end

  // result register with skid stage
  assign s_axis_tready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res_d;
      end
    end else if (accept) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.read_pointer, out_q.payload_byte};
  assign m_axis_tuser_o  = out_q.kind;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while result register is empty");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (rec_len_q > CrcBytes))
    else $error("payload phase with no payload bytes");

  a_offset_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q[1:0] == 2'b00)
    else $error("ring offset not 4-byte aligned");

  a_header_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_H3) |=>
      ((phase_q == PH_H0 && done_q == '0) || done_q == CountW'(HeaderBytes)))
    else $error("bad state after length byte");
`endif

endmodule

[tb/rrd_checker.sv]
// Checker for the receive ring deframer: watches the config port and both streams,
// predicts one result per accepted ring byte and compares in order.
// Depends on rrd_pkg.
module rrd_checker
  import rrd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,    // [7:0] ring_byte
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [23:0] out_data_i,   // [7:0] payload_byte, [23:8] read_pointer
  input  logic [2:0]  out_user_i,   // [2:0] kind
  output int          fail_count_o,
  output int          backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_e          phase;
  logic [LenW-1:0] rec_len;
  logic [16:0]     bytes_done;
  logic [LenW-1:0] ring_offset;
  logic [LenW-1:0] max_len;
  result_t         results_due[$];
  int              fails = 0;

  assign fail_count_o = fails;
  assign backlog_o    = results_due.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fails < 20) begin
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    end
    fails++;
  endtask

  function automatic result_t deframe_byte(input logic [7:0] b);
    result_t     r;
    logic [31:0] padded;
    logic [31:0] next_offset;
    r.kind         = KIND_SKIP;
    r.payload_byte = '0;
    padded         = ({16'd0, rec_len} + 32'(HeaderBytes) + 32'd3) & ~32'd3;
    case (phase)
      PH_H1: begin
        phase      = PH_H2;
        bytes_done = 17'd2;
      end
      PH_H2: begin
        rec_len    = {8'd0, b};
        phase      = PH_H3;
        bytes_done = 17'd3;
      end
      PH_H3: begin
        rec_len = {b, rec_len[7:0]};
        if (rec_len < CrcBytes || rec_len > max_len) begin
          r.kind      = KIND_ERROR;
          ring_offset = '0;
          phase       = PH_H0;
          bytes_done  = '0;
          rec_len     = '0;
        end else begin
          bytes_done = 17'(HeaderBytes);
          phase      = (rec_len > CrcBytes) ? PH_PAYLOAD : PH_TAIL;
        end
      end
      PH_PAYLOAD: begin
        bytes_done     = bytes_done + 17'd1;
        r.payload_byte = b;
        if (bytes_done >= {1'b0, rec_len}) begin
          r.kind = KIND_LAST;
          phase  = PH_TAIL;
        end else begin
          r.kind = KIND_PAYLOAD;
        end
      end
      PH_TAIL: begin
        bytes_done = bytes_done + 17'd1;
        if ({15'd0, bytes_done} >= padded) begin
          r.kind      = KIND_DONE;
          next_offset = ({16'd0, ring_offset} + {16'd0, rec_len} + 32'(HeaderBytes) + 32'd3)
                        & ~32'd3;
          ring_offset = next_offset[15:0];
          phase       = PH_H0;
          bytes_done  = '0;
        end
      end
      default: begin
        phase      = PH_H1;
        bytes_done = 17'd1;
      end
    endcase
    r.read_pointer = ring_offset - ReadPtrBias;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      phase       = PH_H0;
      rec_len     = '0;
      bytes_done  = '0;
      ring_offset = '0;
      max_len     = MaxLenResetVal;
      results_due.delete();
    end else begin
      if (cfg_we_i) begin
        max_len = cfg_wdata_i;
      end
      // results leave through a register after their byte, so pop before push
      if (out_valid_i && out_ready_i) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected item", {5'd0, out_user_i, out_data_i}, 32'd0);
        end else begin
          want = results_due.pop_front();
          if (out_user_i != want.kind) begin
            report_mismatch("kind", 32'(out_user_i), 32'(want.kind));
          end
          if (out_data_i[7:0] != want.payload_byte) begin
            report_mismatch("payload_byte", 32'(out_data_i[7:0]), 32'(want.payload_byte));
          end
          if (out_data_i[23:8] != want.read_pointer) begin
            report_mismatch("read_pointer", 32'(out_data_i[23:8]), 32'(want.read_pointer));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        results_due.push_back(deframe_byte(in_data_i));
      end
    end
  end

endmodule

[tb/testbench.sv]
// Top of the receive ring deframer testbench: clock, reset, ring byte stimulus
// in config phases, output back-pressure and the verdict.
// Depends on rrd_pkg, receive_ring_deframer and rrd_checker.
module testbench;
  import rrd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit    = 3_000_000;
  localparam int unsigned HoldOffCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_valid;
  logic        s_ready;
  logic [7:0]  s_data;
  logic        m_valid;
  logic        m_ready;
  logic [23:0] m_data;
  logic [2:0]  m_user;
  int          fail_total;
  int          backlog;

  int unsigned cur_max = MaxLenResetVal;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned gap_limit = 6;
  bit          hold_off_req = 1'b0;
  bit          hold_off_done = 1'b0;
  int unsigned cycle_count = 0;

  // length 4 record, a length error, then a length 6 record with two pad bytes
  logic [7:0] opening_bytes [0:23] = '{
    8'h00, 8'hFF, 8'h04, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55,
    8'h00, 8'h00, 8'hFF, 8'hFF,
    8'h5A, 8'hA5, 8'h06, 8'h00, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC
  };

  always #6 clk_i = ~clk_i;

  receive_ring_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  rrd_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_user_i   (m_user),
    .fail_count_o (fail_total),
    .backlog_o    (backlog)
  );

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    bit          took;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_limit);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_data  <= b;
    do begin
      @(negedge clk_i);
      took = s_ready;
      @(posedge clk_i);
    end while (!took);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_record(input int unsigned len);
    int unsigned total;
    total = (len + 32'(HeaderBytes) + 32'd3) & ~32'd3;
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    if (len >= 4 && len <= cur_max) begin
      for (int unsigned i = 4; i < total; i++) begin
        send_byte(8'($urandom));
      end
    end
  endtask

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (cur_max < 4) begin
      return (r < 50) ? $urandom_range(0, 4) : $urandom_range(0, 65535);
    end
    if (r < 8) return $urandom_range(0, 3);
    if (r < 14) return (cur_max < 65535) ? $urandom_range(cur_max + 1, 65535) : 4;
    if (r < 20 && cur_max <= 256) return cur_max;
    return $urandom_range(4, (cur_max < 40) ? cur_max : 40);
  endfunction

  task automatic settle();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (backlog != 0);
    @(posedge clk_i);
  endtask

  task automatic write_max(input logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_max = v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_records(input int unsigned target, input bit with_noise);
    int unsigned stop_at;
    stop_at = bytes_sent + target;
    while (bytes_sent < stop_at) begin
      if (with_noise && $urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
      end else begin
        send_record(pick_length());
      end
    end
  endtask

  initial begin
    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);
    hold_off_req = 1'b1;
    run_records(40, 1'b0);
    settle();

    // widest maximum: a record whose length has a nonzero high byte
    write_max(16'hFFFF);
    gap_limit = 1;
    send_record(256);
    gap_limit = 6;
    run_records(40, 1'b0);
    settle();

    write_max(16'd3);
    send_record(3);
    send_record(4);
    run_records(32, 1'b0);
    settle();

    write_max(16'd4);
    send_record(4);
    send_record(5);
    run_records(50, 1'b0);
    settle();

    write_max(16'd0);
    run_records(20, 1'b0);
    settle();

    write_max(16'($urandom_range(8, 64)));
    run_records(100, 1'b1);
    settle();

    repeat (4) @(posedge clk_i);
    if (fail_total == 0) begin
      $display("** receive_ring_deframer: PASSED **");
    end else begin
      $display("** receive_ring_deframer: FAILED **");
    end
    $finish;
  end

  initial begin
    logic [15:0] mask;
    int unsigned slot;
    mask = '1;
    slot = 0;
    m_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        m_ready <= 1'b0;
        for (int unsigned n = 0; n < HoldOffCycles; n++) @(posedge clk_i);
      end else begin
        if (slot == 0) begin
          case ($urandom_range(0, 3))
            0:       mask = '1;
            1:       mask = 16'($urandom);
            2:       mask = 16'($urandom | $urandom);
            default: mask = 16'($urandom & $urandom);
          endcase
        end
        m_ready <= mask[slot];
        slot = (slot + 1) % 16;
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** receive_ring_deframer: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rrd_pkg.sv
rtl/core/receive_ring_deframer.sv
tb/rrd_checker.sv
tb/testbench.sv
